// ===== hw/rtl/smd_pkg.sv =====
// Shared types, constants and tables for the SHA-256 message digest core.
// No dependencies; compiled first.

package smd_pkg;

    typedef logic [31:0] t_word;

    // Eight 32-bit words; index 0 is word a (or h0 for the chaining words).
    typedef logic [7:0][31:0] t_work;

    // Sixteen-word rolling schedule, which also serves as the block buffer.
    typedef logic [15:0][31:0] t_window;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FOLD,
        S_PAD,
        S_LEN,
        S_OUT
    } t_state;

    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [5:0] PAD_LIMIT  = 6'd56;
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [1:0] PART_LAST  = 2'd3;

    function automatic t_work h_init();
        t_work v;
        v[0] = 32'h6a09e667;
        v[1] = 32'hbb67ae85;
        v[2] = 32'h3c6ef372;
        v[3] = 32'ha54ff53a;
        v[4] = 32'h510e527f;
        v[5] = 32'h9b05688c;
        v[6] = 32'h1f83d9ab;
        v[7] = 32'h5be0cd19;
        return v;
    endfunction

    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

// ===== hw/rtl/smd_ifs.sv =====
// Valid/ready channel interfaces for the SHA-256 message digest core.
// Depends on nothing; payload fields follow the core's byte and digest words.

interface smd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface smd_digest_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_part;
    logic [1:0]  part_index;
    logic        last_part;

    modport source (output valid, digest_part, part_index, last_part, input ready);
    modport sink   (input valid, digest_part, part_index, last_part, output ready);
endinterface

// ===== hw/rtl/smd_round.sv =====
// One SHA-256 round plus the next message schedule word.
// Depends on smd_pkg for the word types.

module smd_round (
    input  smd_pkg::t_work i_work,
    input  smd_pkg::t_word i_k,
    input  smd_pkg::t_word i_w,
    input  smd_pkg::t_word i_win1,
    input  smd_pkg::t_word i_win9,
    input  smd_pkg::t_word i_win14,
    output smd_pkg::t_work o_work,
    output smd_pkg::t_word o_w_next
);

    function automatic smd_pkg::t_word rotr(input smd_pkg::t_word v, input int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    smd_pkg::t_word big_s0, big_s1, ch, maj, t1, t2, sig0, sig1;

    always_comb begin
        big_s1 = rotr(i_work[4], 6) ^ rotr(i_work[4], 11) ^ rotr(i_work[4], 25);
        big_s0 = rotr(i_work[0], 2) ^ rotr(i_work[0], 13) ^ rotr(i_work[0], 22);
        ch     = (i_work[4] & i_work[5]) ^ (~i_work[4] & i_work[6]);
        maj    = (i_work[0] & i_work[1]) ^ (i_work[0] & i_work[2]) ^ (i_work[1] & i_work[2]);
        t1     = i_work[7] + big_s1 + ch + i_k + i_w;
        t2     = big_s0 + maj;

        o_work[7] = i_work[6];
        o_work[6] = i_work[5];
        o_work[5] = i_work[4];
        o_work[4] = i_work[3] + t1;
        o_work[3] = i_work[2];
        o_work[2] = i_work[1];
        o_work[1] = i_work[0];
        o_work[0] = t1 + t2;

        // The window holds W[t] .. W[t+15]; this builds W[t+16].
        sig0     = rotr(i_win1, 7) ^ rotr(i_win1, 18) ^ (i_win1 >> 3);
        sig1     = rotr(i_win14, 17) ^ rotr(i_win14, 19) ^ (i_win14 >> 10);
        o_w_next = sig1 + i_win9 + sig0 + i_w;
    end

endmodule

// ===== hw/rtl/sha256_message_digest_core.sv =====
// SHA-256 message digest core: top level with sequencer, buffer and chaining state.
// Depends on smd_pkg, smd_ifs (smd_byte_if, smd_digest_if) and smd_round.

// Usage:
// The message arrives on i_msg, one word per handshake: a byte with a present
// flag, and an end_of_message flag on the final word. A word may carry no byte,
// so an empty message is hashed by a single word with only end_of_message set.
// The digest leaves on o_dig as four 64-bit words, h0 in the upper half of part
// 0, with last_part set on part 3.
// Flow: a word that neither completes a 64-byte block nor ends the message
// leaves i_msg.ready high. A word that completes a block holds i_msg.ready
// low while the single round unit runs 64 rounds and the chaining words are
// folded in. The final word costs a padding step plus one compression, or two
// compressions when the padding spills into an extra block, after which the
// four digest words are offered back to back. A final word whose byte completes
// a block first spends a compression on that block before its padding step.
// While digest words wait on o_dig.ready the core holds them stable and keeps
// i_msg.ready low; after part 3 is taken it restarts with fresh chaining words
// and a zero byte count. Reset (synchronous, active low) returns the core to
// idle with the initial chaining words and an empty message.

module sha256_message_digest_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    smd_byte_if.sink            i_msg,
    smd_digest_if.source        o_dig
);

    smd_pkg::t_state  r_state, n_state;
    smd_pkg::t_work   r_chain, n_chain;
    smd_pkg::t_work   r_work, n_work;
    smd_pkg::t_window r_win, n_win;
    logic [60:0]      r_count, n_count;
    logic [5:0]       r_round, n_round;
    logic [1:0]       r_part, n_part;
    logic             r_final, n_final;
    logic             r_padded, n_padded;
    logic             r_len_done, n_len_done;

    smd_pkg::t_work   rnd_work;
    smd_pkg::t_word   rnd_w_next;
    logic [60:0]      cnt_inc;
    logic [63:0]      bit_len;
    logic [4:0]       lane_shift;
    logic [5:0]       pos;
    logic [5:0]       byte_idx;
    logic             in_acc;
    logic             out_acc;

    smd_round u_round (
        .i_work   (r_work),
        .i_k      (smd_pkg::round_k(r_round)),
        .i_w      (r_win[0]),
        .i_win1   (r_win[1]),
        .i_win9   (r_win[9]),
        .i_win14  (r_win[14]),
        .o_work   (rnd_work),
        .o_w_next (rnd_w_next)
    );

    assign i_msg.ready       = (r_state == smd_pkg::S_IDLE);
    assign o_dig.valid       = (r_state == smd_pkg::S_OUT);
    assign o_dig.digest_part = {r_chain[{r_part, 1'b0}], r_chain[{r_part, 1'b1}]};
    assign o_dig.part_index  = r_part;
    assign o_dig.last_part   = (r_part == smd_pkg::PART_LAST);

    assign in_acc     = i_msg.valid && i_msg.ready;
    assign out_acc    = o_dig.valid && o_dig.ready;
    assign cnt_inc    = r_count + 61'd1;
    assign bit_len    = {r_count, 3'b000};
    assign pos        = r_count[5:0];
    assign lane_shift = {~r_count[1:0], 3'b000};

    always_comb begin
        n_state    = r_state;
        n_chain    = r_chain;
        n_work     = r_work;
        n_win      = r_win;
        n_count    = r_count;
        n_round    = r_round;
        n_part     = r_part;
        n_final    = r_final;
        n_padded   = r_padded;
        n_len_done = r_len_done;
        byte_idx   = '0;

        case (r_state)
            smd_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_msg.byte_present) begin
                        // Bytes pack big-endian into the schedule words.
                        n_win[r_count[5:2]] = (r_win[r_count[5:2]] & ~(32'hff << lane_shift))
                                            | ({24'h0, i_msg.data_byte} << lane_shift);
                        n_count = cnt_inc;
                        if (cnt_inc[5:0] == 6'd0) begin
                            n_state = smd_pkg::S_ROUND;
                            n_work  = r_chain;
                            n_round = '0;
                            n_final = i_msg.end_of_message;
                        end else if (i_msg.end_of_message) begin
                            n_state = smd_pkg::S_PAD;
                        end
                    end else if (i_msg.end_of_message) begin
                        n_state = smd_pkg::S_PAD;
                    end
                end
            end
            smd_pkg::S_ROUND: begin
                n_work  = rnd_work;
                n_win   = {rnd_w_next, r_win[15:1]};
                n_round = r_round + 6'd1;
                if (r_round == smd_pkg::ROUND_LAST) begin
                    n_state = smd_pkg::S_FOLD;
                end
            end
            smd_pkg::S_FOLD: begin
                for (int i = 0; i < 8; i++) begin
                    n_chain[i] = r_chain[i] + r_work[i];
                end
                if (r_len_done) begin
                    n_state = smd_pkg::S_OUT;
                end else if (r_padded) begin
                    n_state = smd_pkg::S_LEN;
                end else if (r_final) begin
                    n_state = smd_pkg::S_PAD;
                end else begin
                    n_state = smd_pkg::S_IDLE;
                end
            end
            smd_pkg::S_PAD: begin
                // Marker byte at the current position, zeros after it.
                for (int i = 0; i < 16; i++) begin
                    for (int b = 0; b < 4; b++) begin
                        byte_idx = 6'(4 * i + b);
                        if (byte_idx == pos) begin
                            n_win[i][8 * (3 - b) +: 8] = smd_pkg::PAD_BYTE;
                        end else if (byte_idx > pos) begin
                            n_win[i][8 * (3 - b) +: 8] = 8'h00;
                        end
                    end
                end
                // The length fits in this block only if the marker lands before it.
                if (pos < smd_pkg::PAD_LIMIT) begin
                    n_win[14]  = bit_len[63:32];
                    n_win[15]  = bit_len[31:0];
                    n_len_done = 1'b1;
                end
                n_padded = 1'b1;
                n_state  = smd_pkg::S_ROUND;
                n_work   = r_chain;
                n_round  = '0;
            end
            smd_pkg::S_LEN: begin
                for (int i = 0; i < 14; i++) begin
                    n_win[i] = '0;
                end
                n_win[14]  = bit_len[63:32];
                n_win[15]  = bit_len[31:0];
                n_len_done = 1'b1;
                n_state    = smd_pkg::S_ROUND;
                n_work     = r_chain;
                n_round    = '0;
            end
            smd_pkg::S_OUT: begin
                if (out_acc) begin
                    if (r_part == smd_pkg::PART_LAST) begin
                        n_state    = smd_pkg::S_IDLE;
                        n_chain    = smd_pkg::h_init();
                        n_count    = '0;
                        n_part     = '0;
                        n_final    = 1'b0;
                        n_padded   = 1'b0;
                        n_len_done = 1'b0;
                    end else begin
                        n_part = r_part + 2'd1;
                    end
                end
            end
            default: begin
                n_state = smd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= smd_pkg::S_IDLE;
            r_chain    <= smd_pkg::h_init();
            r_count    <= '0;
            r_round    <= '0;
            r_part     <= '0;
            r_final    <= 1'b0;
            r_padded   <= 1'b0;
            r_len_done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_chain    <= n_chain;
            r_count    <= n_count;
            r_round    <= n_round;
            r_part     <= n_part;
            r_final    <= n_final;
            r_padded   <= n_padded;
            r_len_done <= n_len_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_win  <= n_win;
    end

endmodule

// ===== hw/rtl/smd_checker.sv =====
// Port-level assertions for the SHA-256 message digest core, bound to the top level.
// Depends on sha256_message_digest_core and its smd_byte_if / smd_digest_if ports.

module smd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_digest_part,
    input logic [1:0]  i_part_index,
    input logic        i_last_part
);

    // A digest word that is stalled must not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_digest_part)
            && $stable(i_part_index))
        else $error("stalled digest word changed");

    // The core never takes message bytes while a digest is being delivered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while digest pending");

    // The four digest parts come in order without gaps.
    a_part_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last_part |=>
            i_out_valid && (i_part_index == $past(i_part_index) + 2'd1))
        else $error("digest part sequence broken");

    // Only the fourth part is flagged last.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last_part == (i_part_index == smd_pkg::PART_LAST)))
        else $error("last_part does not match part_index");

    // After the final part the core is back to taking bytes.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_last_part |=> i_in_ready && !i_out_valid)
        else $error("core did not return to idle after digest");

endmodule

bind sha256_message_digest_core smd_checker u_smd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_msg.ready),
    .i_out_valid   (o_dig.valid),
    .i_out_ready   (o_dig.ready),
    .i_digest_part (o_dig.digest_part),
    .i_part_index  (o_dig.part_index),
    .i_last_part   (o_dig.last_part)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sha256_message_digest_core: streams messages byte by byte
// and checks every digest word against an in-bench SHA-256 predictor.
// Depends on smd_pkg, smd_ifs and the core RTL.

module tb;

    localparam int ITEM_TARGET    = 170;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 200;

    localparam logic [0:7][31:0] IV_WORDS = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [0:63][31:0] RK = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    typedef struct packed {
        logic [63:0] part;
        logic [1:0]  idx;
        logic        last_flag;
    } t_digest_word;

    function automatic logic [31:0] ror(input logic [31:0] v, input int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    function automatic logic [31:0] sum0(input logic [31:0] v);
        return ror(v, 2) ^ ror(v, 13) ^ ror(v, 22);
    endfunction

    function automatic logic [31:0] sum1(input logic [31:0] v);
        return ror(v, 6) ^ ror(v, 11) ^ ror(v, 25);
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] v);
        return ror(v, 7) ^ ror(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] v);
        return ror(v, 17) ^ ror(v, 19) ^ (v >> 10);
    endfunction

    class digest_scoreboard;
        logic [31:0]  chain [8];
        logic [7:0]   blk [64];
        logic [60:0]  nbytes;
        t_digest_word digest_q [$];
        int           errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) chain[i] = IV_WORDS[i];
            nbytes = '0;
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] t1, t2;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 16; i < 64; i++)
                w[i] = sig1(w[i-2]) + w[i-7] + sig0(w[i-15]) + w[i-16];
            for (int i = 0; i < 8; i++) v[i] = chain[i];
            for (int r = 0; r < 64; r++) begin
                t1 = v[7] + sum1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[r] + w[r];
                t2 = sum0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
        endfunction

        function void note_word(logic [7:0] d, logic present, logic eom);
            int           pos;
            logic [63:0]  bit_len;
            t_digest_word dw;
            if (present) begin
                blk[nbytes[5:0]] = d;
                nbytes = nbytes + 61'd1;
                if (nbytes[5:0] == 6'd0) compress();
            end
            if (!eom) return;
            pos = int'(nbytes[5:0]);
            blk[pos] = smd_pkg::PAD_BYTE;
            for (int k = pos + 1; k < 64; k++) blk[k] = 8'h00;
            // No room left for the length field: it goes into an extra block.
            if (pos >= int'(smd_pkg::PAD_LIMIT)) begin
                compress();
                for (int k = 0; k < 56; k++) blk[k] = 8'h00;
            end
            bit_len = {nbytes, 3'b000};
            for (int k = 0; k < 8; k++) blk[63-k] = bit_len[8*k +: 8];
            compress();
            for (int k = 0; k < 4; k++) begin
                dw.part      = {chain[2*k], chain[2*k+1]};
                dw.idx       = 2'(k);
                dw.last_flag = (2'(k) == smd_pkg::PART_LAST);
                digest_q.push_back(dw);
            end
            restart();
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_part(logic [63:0] part, logic [1:0] idx, logic last_flag);
            t_digest_word dw;
            if (digest_q.size() == 0) begin
                report($sformatf("digest word %h with nothing pending", part));
                return;
            end
            dw = digest_q.pop_front();
            if (part !== dw.part)
                report($sformatf("digest_part %h, predicted %h", part, dw.part));
            if (idx !== dw.idx)
                report($sformatf("part_index %0d, predicted %0d", idx, dw.idx));
            if (last_flag !== dw.last_flag)
                report($sformatf("last_part %b, predicted %b", last_flag, dw.last_flag));
        endtask

        function int pending();
            return digest_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    smd_byte_if   msg_if ();
    smd_digest_if dig_if ();

    sha256_message_digest_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_if),
        .o_dig   (dig_if)
    );

    digest_scoreboard sb = new();
    bit               quiet;
    int               idle_cycles;
    bit               moved;
    int               items_sent;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Mostly back to back, some short gaps and the odd long one.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task send_word(logic [7:0] d, logic present, logic eom);
        int g;
        g = pick_gap();
        if (g > 0) begin
            msg_if.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        msg_if.valid          <= 1'b1;
        msg_if.data_byte      <= d;
        msg_if.byte_present   <= present;
        msg_if.end_of_message <= eom;
        do @(posedge i_clk); while (!(msg_if.valid && msg_if.ready));
        @(negedge i_clk);
        items_sent++;
    endtask

    task send_message(int len, bit byte_on_last);
        logic [7:0] d;
        for (int i = 0; i < len; i++) begin
            // Empty words sprinkled inside the message must change nothing.
            if ($urandom_range(0, 9) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            d = 8'($urandom);
            send_word(d, 1'b1, (byte_on_last && i == len - 1));
        end
        if (!byte_on_last || len == 0)
            send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        dig_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            int g;
            @(negedge i_clk);
            g = pick_gap();
            if (g > 0) begin
                dig_if.ready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
            dig_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(dig_if.valid && dig_if.ready));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (msg_if.valid && msg_if.ready) begin
                sb.note_word(msg_if.data_byte, msg_if.byte_present, msg_if.end_of_message);
                moved = 1'b1;
            end
            if (dig_if.valid && dig_if.ready) begin
                sb.check_part(dig_if.digest_part, dig_if.part_index, dig_if.last_part);
                moved = 1'b1;
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int r;
        int len;
        i_rst_n               = 1'b0;
        msg_if.valid          = 1'b0;
        msg_if.data_byte      = 8'h00;
        msg_if.byte_present   = 1'b0;
        msg_if.end_of_message = 1'b0;
        idle_cycles           = 0;
        quiet                 = 1'b1;
        items_sent            = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty message, with a stray empty word ahead of it.
        send_word(8'h5a, 1'b0, 1'b0);
        send_word(8'hff, 1'b0, 1'b1);
        // "abc" with the last byte on the final word.
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        // NUL and all-ones bytes, an empty word between, then a bare final word.
        quiet = 1'b0;
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'h3c, 1'b0, 1'b0);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        // A single NUL byte carried on the final word.
        send_word(8'h00, 1'b1, 1'b1);

        while (items_sent < ITEM_TARGET) begin
            quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 65)      len = $urandom_range(0, 8);
            else if (r < 80) len = $urandom_range(9, 40);
            else if (r < 95) len = $urandom_range(52, 66);
            else             len = $urandom_range(118, 130);
            send_message(len, 1'($urandom_range(0, 1)));
        end
        msg_if.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
